@@ sv/csc_pkg.sv @@
// Shared types and constants for the CORDIC sine/cosine core.
// Holds the arctangent table, the gain-compensated start value and the
// control word that travels down the row of rotation cells. No dependencies.
package csc_pkg;

    // Valid flag and quadrant that ride along with each item.
    typedef struct packed {
        logic       valid;
        logic [1:0] quad;
    } csc_ctrl_t;

    // Quadrant codes taken from the top two phase bits.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Width of the full-precision constants below.
    localparam int CONST_WIDTH = 48;

    // Start value for x: 1/K with 2^46 standing for one.
    localparam logic [CONST_WIDTH-1:0] GAIN_CONST = 48'h26DD3B6A10D8;

    // atan(2^-k) with pi/4 equal to 2^46, one entry for every stage.
    localparam logic [CONST_WIDTH-1:0] ATAN_TABLE [CONST_WIDTH] = '{
        48'h400000000000, 48'h25C80A3B3BE6, 48'h13F670B6BDC7, 48'h0A2223A83BBB,
        48'h05161A861CB1, 48'h028BAFC2B209, 48'h0145EC3CB850, 48'h00A2F8AA23A9,
        48'h00517CA68DA2, 48'h0028BE5D7661, 48'h00145F300123, 48'h000A2F982950,
        48'h000517CC19C0, 48'h00028BE60D83, 48'h000145F306D6, 48'h0000A2F9836D,
        48'h0000517CC1B7, 48'h000028BE60DC, 48'h0000145F306E, 48'h00000A2F9837,
        48'h00000517CC1B, 48'h0000028BE60E, 48'h00000145F307, 48'h000000A2F983,
        48'h000000517CC2, 48'h00000028BE61, 48'h000000145F30, 48'h0000000A2F98,
        48'h0000000517CC, 48'h000000028BE6, 48'h0000000145F3, 48'h00000000A2FA,
        48'h00000000517D, 48'h0000000028BE, 48'h00000000145F, 48'h000000000A30,
        48'h000000000518, 48'h00000000028C, 48'h000000000146, 48'h0000000000A3,
        48'h000000000051, 48'h000000000029, 48'h000000000014, 48'h00000000000A,
        48'h000000000005, 48'h000000000003, 48'h000000000001, 48'h000000000000
    };

endpackage

@@ sv/csc_cell.sv @@
// One rotation-mode CORDIC cell: a single micro-rotation and its registers.
// Depends on csc_pkg for the arctangent table and the control word type.
module csc_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int STAGE      = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  csc_pkg::csc_ctrl_t     in_ctrl,
    input  logic [DATA_WIDTH+1:0]  in_x,
    input  logic [DATA_WIDTH+1:0]  in_y,
    input  logic [DATA_WIDTH+1:0]  in_z,
    output csc_pkg::csc_ctrl_t     out_ctrl,
    output logic [DATA_WIDTH+1:0]  out_x,
    output logic [DATA_WIDTH+1:0]  out_y,
    output logic [DATA_WIDTH+1:0]  out_z
);
    import csc_pkg::*;

    localparam int IW         = DATA_WIDTH + 2;
    localparam int ATAN_SHIFT = CONST_WIDTH - DATA_WIDTH - 1;
    localparam logic [CONST_WIDTH-1:0] ANGLE_FULL = ATAN_TABLE[STAGE] >> ATAN_SHIFT;
    localparam logic [IW-1:0] ANGLE = ANGLE_FULL[IW-1:0];

    logic          valid_reg;
    logic [1:0]    quad_reg;
    logic [IW-1:0] x_reg, x_next;
    logic [IW-1:0] y_reg, y_next;
    logic [IW-1:0] z_reg, z_next;
    logic [IW-1:0] x_shift;
    logic [IW-1:0] y_shift;

    // Micro-rotation: the sign of the residual angle picks the direction.
    always_comb
    begin
        x_shift = $unsigned($signed(in_x) >>> STAGE);
        y_shift = $unsigned($signed(in_y) >>> STAGE);
        if (in_z[IW-1])
        begin
            x_next = in_x + y_shift;
            y_next = in_y - x_shift;
            z_next = in_z + ANGLE;
        end
        else
        begin
            x_next = in_x - y_shift;
            y_next = in_y + x_shift;
            z_next = in_z - ANGLE;
        end
    end

    // Control register: only the valid flag needs a reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_ctrl.valid;
        end
    end

    // Payload registers advance with the row.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg <= in_ctrl.quad;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign out_ctrl.valid = valid_reg;
    assign out_ctrl.quad  = quad_reg;
    assign out_x          = x_reg;
    assign out_y          = y_reg;
    assign out_z          = z_reg;

endmodule

@@ sv/csc_fold.sv @@
// Quadrant fold and output stage with a skid register for the result stream.
// Depends on csc_pkg for the quadrant codes and the control word type.
module csc_fold #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  csc_pkg::csc_ctrl_t     in_ctrl,
    input  logic [DATA_WIDTH+1:0]  in_x,
    input  logic [DATA_WIDTH+1:0]  in_y,
    output logic                   en,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DATA_WIDTH-1:0]  out_cosine,
    output logic [DATA_WIDTH-1:0]  out_sine
);
    import csc_pkg::*;

    localparam int IW = DATA_WIDTH + 2;

    logic [IW-1:0]         c_full;
    logic [IW-1:0]         s_full;
    logic [IW-1:0]         c_neg;
    logic [IW-1:0]         s_neg;
    logic [DATA_WIDTH-1:0] cos_fold;
    logic [DATA_WIDTH-1:0] sin_fold;
    logic                  take_in;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [DATA_WIDTH-1:0] out_cos_reg, out_cos_next;
    logic [DATA_WIDTH-1:0] out_sin_reg, out_sin_next;
    logic [DATA_WIDTH-1:0] skid_cos_reg, skid_cos_next;
    logic [DATA_WIDTH-1:0] skid_sin_reg, skid_sin_next;

    // Scale by a quarter, then swap and negate by quadrant.
    always_comb
    begin
        c_full = $unsigned($signed(in_x) >>> 2);
        s_full = $unsigned($signed(in_y) >>> 2);
        c_neg  = ~c_full + IW'(1);
        s_neg  = ~s_full + IW'(1);
        unique case (in_ctrl.quad)
            QUAD_FIRST:
            begin
                cos_fold = c_full[DATA_WIDTH-1:0];
                sin_fold = s_full[DATA_WIDTH-1:0];
            end
            QUAD_SECOND:
            begin
                cos_fold = s_neg[DATA_WIDTH-1:0];
                sin_fold = c_full[DATA_WIDTH-1:0];
            end
            QUAD_THIRD:
            begin
                cos_fold = c_neg[DATA_WIDTH-1:0];
                sin_fold = s_neg[DATA_WIDTH-1:0];
            end
            QUAD_FOURTH:
            begin
                cos_fold = s_full[DATA_WIDTH-1:0];
                sin_fold = c_neg[DATA_WIDTH-1:0];
            end
            default:
            begin
                cos_fold = c_full[DATA_WIDTH-1:0];
                sin_fold = s_full[DATA_WIDTH-1:0];
            end
        endcase
    end

    // The row moves whenever the skid register is free.
    assign en      = !skid_valid_reg;
    assign take_in = en && in_ctrl.valid;

    // Output register plus skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_cos_next    = out_cos_reg;
        out_sin_next    = out_sin_reg;
        skid_cos_next   = skid_cos_reg;
        skid_sin_next   = skid_sin_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_cos_next    = skid_cos_reg;
                out_sin_next    = skid_sin_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take_in;
                out_cos_next   = cos_fold;
                out_sin_next   = sin_fold;
            end
        end
        else if (take_in)
        begin
            skid_valid_next = 1'b1;
            skid_cos_next   = cos_fold;
            skid_sin_next   = sin_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cos_reg  <= out_cos_next;
        out_sin_reg  <= out_sin_next;
        skid_cos_reg <= skid_cos_next;
        skid_sin_reg <= skid_sin_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_cosine = out_cos_reg;
    assign out_sine   = out_sin_reg;

    // The skid register only fills behind a held output.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A result arriving at a stalled output must land in the skid register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && take_in) |=> skid_valid_reg)
        else $error("result lost at stalled output");

    // Draining the skid register moves it into the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register not drained");

endmodule

@@ sv/cordic_sine_cosine_core.sv @@
// Top level of the CORDIC sine/cosine core: input mapping, the row of
// rotation cells and the output stage. Depends on csc_pkg, csc_cell, csc_fold.
//
// Usage:
//   The slave stream carries one phase word per transfer; a full turn is
//   2^PHASE_WIDTH and the top two phase bits select the quadrant. The master
//   stream returns one cosine/sine pair per transfer, two's complement, with
//   an amplitude of about 2^(DATA_WIDTH-2).
//   The datapath is a row of DATA_WIDTH rotation cells, one micro-rotation
//   each, followed by the quadrant fold and an output register.
//   A result passes the register of each cell in turn and then the output
//   register before it appears on the master side.
//   Throughput: one transfer per clock in and out while nothing stalls;
//   every cell takes a new item in each cycle unless the row is frozen.
//   Reset clears all valid flags; the payload registers are not reset.
//   When the receiver stalls, the output register holds its result and the
//   skid register takes the next one; only when the skid register is full
//   does the whole row freeze and s_tready drop.
module cordic_sine_cosine_core #(
    parameter int DATA_WIDTH  = 16,
    parameter int PHASE_WIDTH = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: phase.
    input  logic [((PHASE_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: cosine, sine.
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata
);
    import csc_pkg::*;

    localparam int IW         = DATA_WIDTH + 2;
    localparam int OUT_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int GAIN_SHIFT = CONST_WIDTH - DATA_WIDTH - 2;
    localparam logic [CONST_WIDTH-1:0] GAIN_FULL = GAIN_CONST >> GAIN_SHIFT;
    localparam logic [IW-1:0] X_START = GAIN_FULL[IW-1:0];

    logic [PHASE_WIDTH-1:0] phase;
    logic [PHASE_WIDTH-3:0] angle;
    logic [IW-1:0]          z_start;
    logic                   en;
    logic [DATA_WIDTH-1:0]  cosine;
    logic [DATA_WIDTH-1:0]  sine;

    csc_ctrl_t     ctrl [DATA_WIDTH+1];
    logic [IW-1:0] x    [DATA_WIDTH+1];
    logic [IW-1:0] y    [DATA_WIDTH+1];
    logic [IW-1:0] z    [DATA_WIDTH+1];

    // Split the phase into quadrant and in-quadrant angle.
    assign phase = s_tdata[PHASE_WIDTH-1:0];
    assign angle = phase[PHASE_WIDTH-3:0];

    // Scale the angle so that a quarter turn is 2^DATA_WIDTH.
    generate
        if (PHASE_WIDTH - 1 < DATA_WIDTH)
        begin : g_angle_up
            assign z_start = {2'b00, angle, {(DATA_WIDTH - PHASE_WIDTH + 2){1'b0}}};
        end
        else
        begin : g_angle_down
            assign z_start = {2'b00, angle[PHASE_WIDTH-3 -: DATA_WIDTH-2], 2'b00};
        end
    endgenerate

    // Feed of the first cell.
    assign ctrl[0].valid = s_tvalid;
    assign ctrl[0].quad  = phase[PHASE_WIDTH-1 -: 2];
    assign x[0]          = X_START;
    assign y[0]          = '0;
    assign z[0]          = z_start;
    assign s_tready      = en;

    // Row of rotation cells.
    generate
        for (genvar k = 0; k < DATA_WIDTH; k++)
        begin : g_cell
            csc_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .STAGE      (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_ctrl  (ctrl[k]),
                .in_x     (x[k]),
                .in_y     (y[k]),
                .in_z     (z[k]),
                .out_ctrl (ctrl[k+1]),
                .out_x    (x[k+1]),
                .out_y    (y[k+1]),
                .out_z    (z[k+1])
            );
        end
    endgenerate

    // Quadrant fold and output stage.
    csc_fold #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctrl    (ctrl[DATA_WIDTH]),
        .in_x       (x[DATA_WIDTH]),
        .in_y       (y[DATA_WIDTH]),
        .en         (en),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cosine (cosine),
        .out_sine   (sine)
    );

    assign m_tdata = OUT_WIDTH'({sine, cosine});

    // Residual angle of the last cell is unused by the fold.
    logic unused_z;
    assign unused_z = ^z[DATA_WIDTH];

endmodule
